/* src/frame_interval_window_stats_assert.svh */
// Assertion macros for the frame interval window statistics block.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef FRAME_INTERVAL_WINDOW_STATS_ASSERT_SVH
`define FRAME_INTERVAL_WINDOW_STATS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fiws assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FIWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fiws assertion failed");

`endif

/* src/fiws_pkg.sv */
package fiws_pkg;

    // Width of one stored interval and of every statistic.
    localparam int unsigned VALUE_W = 23;
    localparam int unsigned RAW_W   = 24;
    localparam int unsigned HELD_W  = 8;

    // Operation codes carried by an input item.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic                    sample_finite;
        logic signed [RAW_W-1:0] interval_us;
    } t_fiws_in;

    typedef struct packed {
        logic                  accepted;
        logic [VALUE_W-1:0]    current_us;
        logic [VALUE_W-1:0]    average_us;
        logic [VALUE_W-1:0]    minimum_us;
        logic [VALUE_W-1:0]    maximum_us;
        logic [HELD_W-1:0]     samples_held;
    } t_fiws_out;

    // Control shared by every cell of the history chain.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

/* src/fiws_cell.sv */
module fiws_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fiws_pkg::t_cell_ctrl          i_ctrl,
    input  logic [fiws_pkg::VALUE_W-1:0]  i_val,
    input  logic                          i_vld,
    output logic [fiws_pkg::VALUE_W-1:0]  o_val,
    output logic                          o_vld
);
    import fiws_pkg::*;

    logic [VALUE_W-1:0] r_val;
    logic               r_vld;

    // One history slot: takes its neighbour's contents on every shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_val <= i_val;
        end
    end

    assign o_val = r_val;
    assign o_vld = r_vld;

endmodule

/* src/fiws_div.sv */
module fiws_div #(
    parameter int unsigned DIVIDEND_W = 31,
    parameter int unsigned DIVISOR_W  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);
    import fiws_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_fits;

    // Restoring division, one quotient bit per cycle, most significant first.
    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIVIDEND_W-2:0], w_fits};
                r_rem <= w_fits ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* src/frame_interval_window_stats.sv */
// Frame interval window statistics. Each input item is either a frame
// interval sample in whole microseconds or a request to clear the history.
// A sample is stored only when capture is not paused, it is flagged finite
// and it is above zero; the last HISTORY_DEPTH stored samples are kept in a
// chain of cells that rotates once round after every stored sample, feeding
// a running sum, minimum and maximum, after which a bit-serial divider forms
// the truncated mean. An item that stores a sample is therefore held up by
// the rotation of the chain and then the divider; a rejected sample or a
// clear request goes from idle straight to the finishing state. One item is
// worked on at a time, and the next item is taken while the previous result
// waits in the output register. Configuration must be written only while
// the block is idle; the block itself does not enforce this.
module frame_interval_window_stats #(
    parameter int unsigned HISTORY_DEPTH = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fiws_pkg::t_fiws_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fiws_pkg::t_fiws_out o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);
    import fiws_pkg::*;

    localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned POS_W  = $clog2(HISTORY_DEPTH);
    localparam int unsigned SUM_W  = VALUE_W + CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DSTART,
        S_DIV,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic                r_capture_paused;
    logic [CNT_W-1:0]    r_count;
    logic [POS_W-1:0]    r_scan_pos;
    logic [VALUE_W-1:0]  r_last;
    logic [VALUE_W-1:0]  r_mean;
    logic [VALUE_W-1:0]  r_low;
    logic [VALUE_W-1:0]  r_high;
    logic [SUM_W-1:0]    r_sum;
    logic [VALUE_W-1:0]  r_acc_low;
    logic [VALUE_W-1:0]  r_acc_high;
    logic                r_accepted;
    logic                r_out_valid;
    t_fiws_out           r_out_data;

    logic                w_in_fire;
    logic                w_clear_fire;
    logic                w_good;
    logic [VALUE_W-1:0]  w_sample;
    t_cell_ctrl          w_ctrl;
    logic [VALUE_W-1:0]  w_val [HISTORY_DEPTH];
    logic                w_vld [HISTORY_DEPTH];
    logic [VALUE_W-1:0]  w_head_val;
    logic                w_head_vld;
    logic [VALUE_W-1:0]  w_tail_val;
    logic                w_tail_vld;
    logic                w_div_start;
    logic                w_div_done;
    logic [SUM_W-1:0]    w_quotient;
    logic                w_out_free;
    logic                w_out_load;
    logic                w_stats_zero;
    logic                w_mean_ordered;

    // Input handshake and sample qualification.
    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_fire    = i_in_valid && o_in_ready;
    assign w_clear_fire = w_in_fire && (i_in_data.operation == OP_CLEAR);
    assign w_sample     = i_in_data.interval_us[VALUE_W-1:0];
    assign w_good       = (i_in_data.operation == OP_SAMPLE) && !r_capture_paused &&
                          i_in_data.sample_finite && !i_in_data.interval_us[RAW_W-1] &&
                          (i_in_data.interval_us != '0);

    // Cell chain control: a stored sample enters at the head, then the chain
    // rotates one full turn with the tail feeding back to the head.
    assign w_ctrl.shift = (w_in_fire && w_good) || (r_state == S_SCAN);
    assign w_ctrl.clear = w_clear_fire;
    assign w_tail_val   = w_val[HISTORY_DEPTH-1];
    assign w_tail_vld   = w_vld[HISTORY_DEPTH-1];
    assign w_head_val   = (r_state == S_IDLE) ? w_sample : w_tail_val;
    assign w_head_vld   = (r_state == S_IDLE) ? 1'b1 : w_tail_vld;

    genvar g;
    generate
        for (g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                fiws_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (w_ctrl),
                    .i_val   (w_head_val),
                    .i_vld   (w_head_vld),
                    .o_val   (w_val[g]),
                    .o_vld   (w_vld[g])
                );
            end else begin : g_body
                fiws_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (w_ctrl),
                    .i_val   (w_val[g-1]),
                    .i_vld   (w_vld[g-1]),
                    .o_val   (w_val[g]),
                    .o_vld   (w_vld[g])
                );
            end
        end
    endgenerate

    // Mean of the window: sum over count.
    assign w_div_start = (r_state == S_DSTART);

    fiws_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = (r_state == S_FINISH) && w_out_free;

    // Sequencer, statistics and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_capture_paused <= 1'b0;
            r_count          <= '0;
            r_scan_pos       <= '0;
            r_last           <= '0;
            r_mean           <= '0;
            r_low            <= '0;
            r_high           <= '0;
            r_accepted       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capture_paused <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_accepted <= w_good;
                        if (i_in_data.operation == OP_CLEAR) begin
                            r_count <= '0;
                            r_last  <= '0;
                            r_mean  <= '0;
                            r_low   <= '0;
                            r_high  <= '0;
                            r_state <= S_FINISH;
                        end else if (w_good) begin
                            r_last     <= w_sample;
                            if (r_count != CNT_W'(HISTORY_DEPTH)) begin
                                r_count <= r_count + 1'b1;
                            end
                            r_scan_pos <= '0;
                            r_sum      <= '0;
                            r_acc_low  <= '1;
                            r_acc_high <= '0;
                            r_state    <= S_SCAN;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_tail_vld) begin
                        r_sum <= r_sum + SUM_W'(w_tail_val);
                        if (w_tail_val < r_acc_low) begin
                            r_acc_low <= w_tail_val;
                        end
                        if (w_tail_val > r_acc_high) begin
                            r_acc_high <= w_tail_val;
                        end
                    end
                    r_scan_pos <= r_scan_pos + 1'b1;
                    if (r_scan_pos == POS_W'(HISTORY_DEPTH - 1)) begin
                        r_state <= S_DSTART;
                    end
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_mean  <= w_quotient[VALUE_W-1:0];
                        r_low   <= r_acc_low;
                        r_high  <= r_acc_high;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_data.accepted     <= r_accepted;
                        r_out_data.current_us   <= r_last;
                        r_out_data.average_us   <= r_mean;
                        r_out_data.minimum_us   <= r_low;
                        r_out_data.maximum_us   <= r_high;
                        r_out_data.samples_held <= HELD_W'(r_count);
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Conditions on the reported statistics used by the checks below.
    assign w_stats_zero   = (r_out_data.minimum_us == '0) &&
                            (r_out_data.maximum_us == '0) &&
                            (r_out_data.average_us == '0);
    assign w_mean_ordered = (r_out_data.minimum_us <= r_out_data.average_us) &&
                            (r_out_data.average_us <= r_out_data.maximum_us);

    // Checks on the window bookkeeping and the reported statistics.
    `include "frame_interval_window_stats_assert.svh"

    `FIWS_ASSERT_NOW(a_count_bounded, 1'b1, r_count <= CNT_W'(HISTORY_DEPTH))
    `FIWS_ASSERT_NEXT(a_clear_empties, w_clear_fire, r_count == '0)
    `FIWS_ASSERT_NOW(a_empty_zero, r_out_valid && (r_count == '0) && (r_state == S_IDLE), w_stats_zero)
    `FIWS_ASSERT_NOW(a_mean_between, r_out_valid && (r_out_data.samples_held != '0), w_mean_ordered)

endmodule
